// ===== design/usn_pkg.sv =====
// Shared constants for the unit surface normal pipeline.
package usn_pkg;

    // Default coordinate width of the edge vector components.
    localparam int COORD_BITS_DEF = 12;

    // Default number of fraction bits of the normal components.
    localparam int FRAC_BITS_DEF = 14;

    // Width of one normal component on the output stream.
    localparam int NORM_BITS = 16;

    // Number of components in a vector.
    localparam int NUM_AXES = 3;

endpackage

// ===== design/usn_sqrt_cell.sv =====
// Square root chain cell: resolves one root bit per enabled cycle.
module usn_sqrt_cell #(
    parameter int RT_W   = 25,
    parameter int PASS_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [2*RT_W-1:0] s_in,
    input  logic [RT_W+1:0]   rem_in,
    input  logic [RT_W-1:0]   root_in,
    input  logic [PASS_W-1:0] pass_in,
    output logic              valid_out,
    output logic [2*RT_W-1:0] s_out,
    output logic [RT_W+1:0]   rem_out,
    output logic [RT_W-1:0]   root_out,
    output logic [PASS_W-1:0] pass_out
);
    localparam int REM_W = RT_W + 2;

    logic              valid_reg;
    logic [2*RT_W-1:0] s_reg,    s_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [PASS_W-1:0] pass_reg;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    // Bring down the next bit pair and try the trial subtrahend 4*root+1.
    always_comb
    begin
        cur       = {rem_in, s_in[2*RT_W-1 -: 2]};
        trial     = (REM_W+2)'({root_in, 2'b01});
        ge        = (cur >= trial);
        rem_next  = ge ? REM_W'(cur - trial) : REM_W'(cur);
        root_next = {root_in[RT_W-2:0], ge};
        s_next    = {s_in[2*RT_W-3:0], 2'b00};
    end

    // Control bit is reset; the data registers just follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pass_reg <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign s_out     = s_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign pass_out  = pass_reg;

endmodule

// ===== design/usn_div_cell.sv =====
// Divider chain cell: one quotient bit of each component per enabled cycle.
module usn_div_cell #(
    parameter int RT_W   = 25,
    parameter int QB     = 15,
    parameter int PASS_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [RT_W-1:0]      len_in,
    input  logic [3*(RT_W+1)-1:0] rem_in,
    input  logic [3*QB-1:0]      q_in,
    input  logic [PASS_W-1:0]    pass_in,
    output logic                 valid_out,
    output logic [RT_W-1:0]      len_out,
    output logic [3*(RT_W+1)-1:0] rem_out,
    output logic [3*QB-1:0]      q_out,
    output logic [PASS_W-1:0]    pass_out
);
    import usn_pkg::*;

    localparam int RW = RT_W + 1;

    logic                 valid_reg;
    logic [RT_W-1:0]      len_reg;
    logic [3*RW-1:0]      rem_reg, rem_next;
    logic [3*QB-1:0]      q_reg,   q_next;
    logic [PASS_W-1:0]    pass_reg;
    logic [RW-1:0]        r;
    logic                 ge;

    // Restoring step on each component: compare, subtract, shift left.
    always_comb
    begin
        rem_next = '0;
        q_next   = '0;
        r        = '0;
        ge       = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            ge = (rem_in[i*RW +: RW] >= RW'(len_in));
            r  = ge ? RW'(rem_in[i*RW +: RW] - RW'(len_in)) : rem_in[i*RW +: RW];
            rem_next[i*RW +: RW] = {r[RT_W-1:0], 1'b0};
            q_next[i*QB +: QB]   = {q_in[i*QB +: QB-1], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            pass_reg <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign len_out   = len_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign pass_out  = pass_reg;

endmodule

// ===== design/unit_surface_normal.sv =====
// Unit surface normal: cross product, length by square root, per-component divide.
// Throughput: one item per cycle while the output register is empty or being taken;
// four front stages form products, cross, squares and sum, then one square root
// cell per root bit and one divider cell per quotient bit.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (rst_n low, asynchronous) clears every valid bit; data registers are not reset.
module unit_surface_normal #(
    parameter int COORD_BITS = usn_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = usn_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y, edge_b_z, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [((3*usn_pkg::NORM_BITS+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0] m_axis_tuser
);
    import usn_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int PW     = 2*CB;
    localparam int MAG_W  = 2*CB;
    localparam int SQ_W   = 2*MAG_W + 2;
    localparam int RT_W   = MAG_W + 1;
    localparam int QB     = FRAC_BITS + 1;
    localparam int QW     = FRAC_BITS + 2;
    localparam int OUT_W  = ((3*NORM_BITS+7)/8)*8;
    localparam int SP_W   = 4 + 3*MAG_W;
    localparam int DP_W   = 4;
    localparam int RW     = RT_W + 1;

    logic adv;
    logic signed [CB-1:0] ax, ay, az, bx, by, bz;

    // Stage registers of the front end.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PW-1:0] p_aybz_reg, p_azby_reg, p_azbx_reg, p_axbz_reg, p_axby_reg, p_aybx_reg;
    logic signed [PW:0]   cx, cy, cz;
    logic [MAG_W-1:0]     mx_reg, my_reg, mz_reg;
    logic [2:0]           sgn2_reg, sgn3_reg, sgn4_reg;
    logic [MAG_W-1:0]     mx3_reg, my3_reg, mz3_reg;
    logic [2*MAG_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]      s_reg;
    logic                 deg_reg;
    logic [MAG_W-1:0]     mx4_reg, my4_reg, mz4_reg;

    // Output register.
    logic                 ov_reg;
    logic [OUT_W-1:0]     odata_reg, odata_next;
    logic                 odeg_reg;

    assign adv           = !ov_reg || m_axis_tready;
    assign s_axis_tready = adv;

    assign ax = s_axis_tdata[0*CB +: CB];
    assign ay = s_axis_tdata[1*CB +: CB];
    assign az = s_axis_tdata[2*CB +: CB];
    assign bx = s_axis_tdata[3*CB +: CB];
    assign by = s_axis_tdata[4*CB +: CB];
    assign bz = s_axis_tdata[5*CB +: CB];

    // Cross product components from registered products.
    always_comb
    begin
        cx = (PW+1)'(p_aybz_reg) - (PW+1)'(p_azby_reg);
        cy = (PW+1)'(p_azbx_reg) - (PW+1)'(p_axbz_reg);
        cz = (PW+1)'(p_axby_reg) - (PW+1)'(p_aybx_reg);
    end

    // Valid bits of the front end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Front end data path: products, cross and magnitude, squares, sum.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_aybz_reg <= ay * bz;
            p_azby_reg <= az * by;
            p_azbx_reg <= az * bx;
            p_axbz_reg <= ax * bz;
            p_axby_reg <= ax * by;
            p_aybx_reg <= ay * bx;

            mx_reg   <= MAG_W'(cx[PW] ? -cx : cx);
            my_reg   <= MAG_W'(cy[PW] ? -cy : cy);
            mz_reg   <= MAG_W'(cz[PW] ? -cz : cz);
            sgn2_reg <= {cz[PW], cy[PW], cx[PW]};

            sqx_reg  <= mx_reg * mx_reg;
            sqy_reg  <= my_reg * my_reg;
            sqz_reg  <= mz_reg * mz_reg;
            mx3_reg  <= mx_reg;
            my3_reg  <= my_reg;
            mz3_reg  <= mz_reg;
            sgn3_reg <= sgn2_reg;

            s_reg    <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);
            deg_reg  <= (sqx_reg == '0) && (sqy_reg == '0) && (sqz_reg == '0);
            mx4_reg  <= mx3_reg;
            my4_reg  <= my3_reg;
            mz4_reg  <= mz3_reg;
            sgn4_reg <= sgn3_reg;
        end
    end

    // Square root chain, one cell per root bit.
    logic              sv   [0:RT_W];
    logic [SQ_W-1:0]   ss   [0:RT_W];
    logic [RT_W+1:0]   srem [0:RT_W];
    logic [RT_W-1:0]   sroot[0:RT_W];
    logic [SP_W-1:0]   spass[0:RT_W];

    assign sv[0]    = v4_reg;
    assign ss[0]    = s_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign spass[0] = {deg_reg, sgn4_reg, mz4_reg, my4_reg, mx4_reg};

    for (genvar k = 0; k < RT_W; k++)
    begin : g_sqrt
        usn_sqrt_cell #(
            .RT_W   (RT_W),
            .PASS_W (SP_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (sv[k]),
            .s_in      (ss[k]),
            .rem_in    (srem[k]),
            .root_in   (sroot[k]),
            .pass_in   (spass[k]),
            .valid_out (sv[k+1]),
            .s_out     (ss[k+1]),
            .rem_out   (srem[k+1]),
            .root_out  (sroot[k+1]),
            .pass_out  (spass[k+1])
        );
    end

    // Divider chain, one cell per quotient bit of all three components.
    logic              dv   [0:QB];
    logic [RT_W-1:0]   dlen [0:QB];
    logic [3*RW-1:0]   drem [0:QB];
    logic [3*QB-1:0]   dq   [0:QB];
    logic [DP_W-1:0]   dpass[0:QB];
    logic [MAG_W-1:0]  fmx, fmy, fmz;

    assign {fmz, fmy, fmx} = spass[RT_W][3*MAG_W-1:0];
    assign dv[0]    = sv[RT_W];
    assign dlen[0]  = sroot[RT_W];
    assign drem[0]  = {RW'(fmz), RW'(fmy), RW'(fmx)};
    assign dq[0]    = '0;
    assign dpass[0] = spass[RT_W][SP_W-1 -: DP_W];

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        usn_div_cell #(
            .RT_W   (RT_W),
            .QB     (QB),
            .PASS_W (DP_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (dv[k]),
            .len_in    (dlen[k]),
            .rem_in    (drem[k]),
            .q_in      (dq[k]),
            .pass_in   (dpass[k]),
            .valid_out (dv[k+1]),
            .len_out   (dlen[k+1]),
            .rem_out   (drem[k+1]),
            .q_out     (dq[k+1]),
            .pass_out  (dpass[k+1])
        );
    end

    // Apply the signs, cut to the output width, zero for a degenerate item.
    logic [QW-1:0] qe;
    logic [QW-1:0] qs;

    always_comb
    begin
        odata_next = '0;
        qe         = '0;
        qs         = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            qe = QW'(dq[QB][i*QB +: QB]);
            qs = dpass[QB][i] ? QW'(-qe) : qe;
            if (!dpass[QB][DP_W-1])
            begin
                odata_next[i*NORM_BITS +: NORM_BITS] = NORM_BITS'($signed(qs));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= dv[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            odata_reg <= odata_next;
            odeg_reg  <= dpass[QB][DP_W-1];
        end
    end

    assign m_axis_tvalid   = ov_reg;
    assign m_axis_tdata    = odata_reg;
    assign m_axis_tuser[0] = odeg_reg;

endmodule

// ===== design/usn_checker.sv =====
// Port-level checks for the unit surface normal block, bound to the top level.
module usn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    // A result held back by the sink stays offered and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("usn: stalled result changed");

    // A degenerate item carries a zero normal.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 48'd0)
        else $error("usn: degenerate item with nonzero normal");

    // A proper normal has at least one nonzero component.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata != 48'd0)
        else $error("usn: zero normal without degenerate flag");

    // Input side is ready whenever the output register is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("usn: input stalled with free output");

endmodule

bind unit_surface_normal usn_checker u_usn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/unit_surface_normal_check.sv =====
// Checker for unit_surface_normal: predicts each normal and compares the output stream.
module unit_surface_normal_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          fail_count,
    output int          normals_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        degenerate;
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
    } normal_t;

    normal_t expected_normals[$];
    int      mismatch_count = 0;

    // Floor of the square root, one result bit per pass.
    function automatic longint unsigned floor_root(input longint unsigned s);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = s;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // One component scaled to Q1.14, truncated toward zero, cut to 16 bits.
    function automatic logic [15:0] scale_axis(input longint c, input longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q   = (mag << usn_pkg::FRAC_BITS_DEF) / len;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    // Cross product of edge a and edge b, then normalized.
    function automatic normal_t predict_normal(input logic [71:0] d);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint unsigned len;
        normal_t r;
        ax = longint'(signed'(d[11:0]));
        ay = longint'(signed'(d[23:12]));
        az = longint'(signed'(d[35:24]));
        bx = longint'(signed'(d[47:36]));
        by = longint'(signed'(d[59:48]));
        bz = longint'(signed'(d[71:60]));
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        len = floor_root(cx * cx + cy * cy + cz * cz);
        if (len == 0)
        begin
            r = '0;
            r.degenerate = 1'b1;
        end
        else
        begin
            r.nx = scale_axis(cx, len);
            r.ny = scale_axis(cy, len);
            r.nz = scale_axis(cz, len);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    assign normals_pending = expected_normals.size();
    assign fail_count      = mismatch_count;

    // Record accepted edges and compare accepted normals.
    always @(posedge clk)
    begin
        normal_t want;
        normal_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_normals.push_back(predict_normal(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser[0], m_axis_tdata[47:32], m_axis_tdata[31:16],
                       m_axis_tdata[15:0]};
                if (expected_normals.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected normal %h", got);
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (want.nx !== got.nx || want.ny !== got.ny || want.nz !== got.nz
                        || want.degenerate !== got.degenerate)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: want %h %h %h %b, got %h %h %h %b",
                                     want.nx, want.ny, want.nz, want.degenerate,
                                     got.nx, got.ny, got.nz, got.degenerate);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/unit_surface_normal_test.sv =====
// Stimulus and verdict for the unit_surface_normal regression.
module unit_surface_normal_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    int          fail_count;
    int          normals_pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          cycle_count = 0;

    unit_surface_normal i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    unit_surface_normal_check i_check (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .normals_pending(normals_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("unit_surface_normal regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = 300;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [71:0] edges(input int ax, ay, az, bx, by, bz);
        logic [11:0] f[6];
        f[0] = 12'(ax); f[1] = 12'(ay); f[2] = 12'(az);
        f[3] = 12'(bx); f[4] = 12'(by); f[5] = 12'(bz);
        return {f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    // Offer one item, idling first at the current rate.
    task automatic send_edges(input logic [71:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic int small_coord();
        return $urandom_range(6) - 3;
    endfunction

    // Random edges: mostly full range, some small, some parallel pairs.
    task automatic send_random(input int count);
        int ax, ay, az, k;
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    ax = small_coord(); ay = small_coord(); az = small_coord();
                    send_edges(edges(ax, ay, az, small_coord(), small_coord(),
                                     small_coord()));
                end
                2:
                begin
                    ax = $urandom_range(40) - 20; ay = $urandom_range(40) - 20;
                    az = $urandom_range(40) - 20; k = $urandom_range(10) - 5;
                    send_edges(edges(ax, ay, az, ax * k, ay * k, az * k));
                end
                default:
                    send_edges(72'({$urandom, $urandom, $urandom}));
            endcase
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (normals_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, axes, degenerate and parallel edges.
        send_edges(edges(0, 0, 0, 0, 0, 0));
        send_edges(edges(1, 0, 0, 0, 1, 0));
        send_edges(edges(0, 1, 0, 0, 0, 1));
        send_edges(edges(0, 0, 1, 1, 0, 0));
        send_edges(edges(0, 1, 0, 1, 0, 0));
        send_edges(edges(-2048, -2048, -2048, -2048, -2048, -2048));
        send_edges(edges(2047, 2047, 2047, 2047, 2047, 2047));
        send_edges(edges(2047, 0, 0, 0, 2047, 0));
        send_edges(edges(-2048, 0, 0, 0, -2048, 0));
        send_edges(edges(-2048, 0, 0, 0, 2047, 0));
        send_edges(edges(2047, -2048, 2047, -2048, 2047, -2048));
        send_edges(edges(-2048, 2047, 0, 2047, 2047, -2048));
        send_edges(edges(3, 6, 9, -1, -2, -3));
        send_edges(edges(1, 2, 3, 2, 4, 6));
        send_edges(edges(1, 1, 0, 1, -1, 0));
        send_edges(edges(1, 2, 3, 4, 5, 6));
        send_edges(edges(-1, -1, -1, 1, 0, 0));
        send_edges(edges(0, 0, 0, 2047, -2048, 5));
        send_edges(edges(1, 0, 0, 0, 0, 0));
        send_edges('1);

        // Idling phases.
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(400);
        send_idle_pct = 70; recv_stall_pct = 0;  send_random(350);
        send_idle_pct = 0;  recv_stall_pct = 70; send_random(350);
        send_idle_pct = 12; recv_stall_pct = 12; send_random(350);

        // Long receiver hold-off while items keep coming.
        send_idle_pct = 0;  recv_stall_pct = 0;
        hold_requests++;
        send_random(350);
        send_random(200);

        drain();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("unit_surface_normal regression: pass");
        else
            $display("unit_surface_normal regression: fail");
        $finish;
    end
endmodule
